[rtl/core/fid_pkg.sv]
package fid_pkg;

  // Field widths of the sample and result requests.
  localparam int unsigned ACCEL_W = 32;
  localparam int unsigned TIME_W  = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION    = 1'd1;

  // Fixed-point constants in Q15.16.
  localparam logic signed [ACCEL_W-1:0] ACCEL_DEFAULT_MIN = 32'sd642679; // 9.8065
  localparam logic signed [ACCEL_W-1:0] ACCEL_TEN         = 32'sd655360; // 10.0

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_sample;
    logic [TIME_W-1:0]         sample_time;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]         longest_duration;
    logic signed [ACCEL_W-1:0] run_min_accel;
  } out_item_t;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_threshold;
    logic [TIME_W-1:0]         min_duration;
  } cfg_t;

endpackage

[rtl/core/fid_cfg_regs.sv]
module fid_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [fid_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [31:0]                    wr_data,
  output fid_pkg::cfg_t                  cfg
);

  fid_pkg::cfg_t cfg_r;

  // Register file; every index in range names a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_threshold <= '0;
      cfg_r.min_duration    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        fid_pkg::REG_ACCEL_THRESHOLD: cfg_r.accel_threshold <= wr_data;
        fid_pkg::REG_MIN_DURATION:    cfg_r.min_duration    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/fid_core.sv]
module fid_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  fid_pkg::in_item_t  item,
  input  fid_pkg::cfg_t      cfg,
  output fid_pkg::out_item_t result
);

  logic                                 batch_started_r, batch_started_nxt;
  logic                                 in_run_r, in_run_nxt;
  logic [fid_pkg::TIME_W-1:0]           run_start_r, run_start_nxt;
  logic [fid_pkg::TIME_W-1:0]           run_duration_r, run_duration_nxt;
  logic signed [fid_pkg::ACCEL_W-1:0]   run_min_r, run_min_nxt;
  logic [fid_pkg::TIME_W-1:0]           best_duration_r, best_duration_nxt;
  logic signed [fid_pkg::ACCEL_W-1:0]   best_min_r, best_min_nxt;

  logic signed [fid_pkg::ACCEL_W-1:0]   base_min;
  logic [fid_pkg::TIME_W-1:0]           dur;
  logic signed [fid_pkg::ACCEL_W-1:0]   rmin;
  logic                                 below;
  logic                                 qualify;

  // One sample's update of the run and best-run trackers.
  always_comb begin
    base_min = batch_started_r ? run_min_r : item.accel_sample;
    below    = item.accel_sample < cfg.accel_threshold;

    run_start_nxt     = run_start_r;
    in_run_nxt        = in_run_r;
    dur               = run_duration_r;
    rmin              = base_min;
    best_duration_nxt = best_duration_r;
    best_min_nxt      = best_min_r;

    if (below) begin
      if (!in_run_r) begin
        run_start_nxt = item.sample_time;
        in_run_nxt    = 1'b1;
      end else begin
        dur = item.sample_time - run_start_r;
        if (item.accel_sample < base_min) begin
          rmin = item.accel_sample;
        end
      end
    end else begin
      rmin       = fid_pkg::ACCEL_TEN;
      dur        = '0;
      in_run_nxt = 1'b0;
    end

    qualify = below && (dur > cfg.min_duration) && (dur > best_duration_r);
    if (qualify) begin
      best_duration_nxt = dur;
      best_min_nxt      = rmin;
    end

    run_duration_nxt  = dur;
    run_min_nxt       = rmin;
    batch_started_nxt = 1'b1;

    result.longest_duration = best_duration_nxt;
    result.run_min_accel    = best_min_nxt;
  end

  // State registers; the last sample of a batch returns them to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.last_sample)) begin
      batch_started_r <= 1'b0;
      in_run_r        <= 1'b0;
      run_start_r     <= '0;
      run_duration_r  <= '0;
      run_min_r       <= '0;
      best_duration_r <= '0;
      best_min_r      <= fid_pkg::ACCEL_DEFAULT_MIN;
    end else if (go) begin
      batch_started_r <= batch_started_nxt;
      in_run_r        <= in_run_nxt;
      run_start_r     <= run_start_nxt;
      run_duration_r  <= run_duration_nxt;
      run_min_r       <= run_min_nxt;
      best_duration_r <= best_duration_nxt;
      best_min_r      <= best_min_nxt;
    end
  end

endmodule

[rtl/core/freefall_interval_detector.sv]
// Data path: a sample request is accepted into the input register, and the core
// processes it from there; a batch result is registered in the result register
// when its last sample leaves the input register.
// Throughput: one sample per cycle; the input stalls only while the consumer holds back
// a finished result in the output register and the held sample also ends a batch.
// Reset: synchronous, active low; clears the run state, configuration and valids.
module freefall_interval_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fid_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fid_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  fid_pkg::cfg_t      cfg;
  fid_pkg::in_item_t  s1_item_r;
  logic               s1_valid_r;
  fid_pkg::out_item_t result;
  fid_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_free;
  logic               go;
  logic               in_take;

  assign cfg_ready = 1'b1;

  fid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held sample moves on unless it ends a batch and the consumer is stalling a valid result.
  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && (!s1_item_r.last_sample || out_free);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  fid_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && s1_item_r.last_sample) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_item_r.last_sample) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/fid_checker.sv]
module fid_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input fid_pkg::out_item_t            out_data
);

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input only stalls behind a result that the consumer is holding.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A batch with no qualifying run reports the default minimum.
  a_default_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.longest_duration == '0)
      |-> out_data.run_min_accel == fid_pkg::ACCEL_DEFAULT_MIN)
    else $error("empty batch result has wrong minimum");

endmodule

bind freefall_interval_detector fid_checker u_fid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/freefall_interval_detector_tb.sv]
`timescale 1ns / 100ps

module freefall_interval_detector_tb;

  localparam int LIMIT       = 400000;
  localparam int DIR_N       = 23;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int SETTLE      = 6;

  typedef struct {
    fid_pkg::in_item_t  s;
    bit                 pinned;
    fid_pkg::out_item_t want;
  } row_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  fid_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fid_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fid_pkg::CFG_IDX_W-1:0] cfg_index = fid_pkg::REG_ACCEL_THRESHOLD;
  logic [31:0]                   cfg_data  = '0;

  // Handshake flags, updated at each rising edge and read at the falling edge.
  bit in_taken;
  bit cfg_taken;

  // Idle rates of the sender and the receiver, in percent.
  int send_gap_pct;
  int stall_pct;

  // Pinned expectation for a directed row, used instead of the prediction.
  bit                 pinned_on;
  fid_pkg::out_item_t pinned_rep;

  // Predicted configuration and run state.
  logic signed [fid_pkg::ACCEL_W-1:0] thr_q;
  logic [fid_pkg::TIME_W-1:0]         min_len_q;
  bit                                 batch_open;
  bit                                 run_open;
  logic [fid_pkg::TIME_W-1:0]         run_t0;
  logic [fid_pkg::TIME_W-1:0]         run_len;
  logic signed [fid_pkg::ACCEL_W-1:0] run_low;
  logic [fid_pkg::TIME_W-1:0]         best_len;
  logic signed [fid_pkg::ACCEL_W-1:0] best_low;

  fid_pkg::out_item_t due_reports[$];
  int                 fault_count;
  int                 cycles;
  row_t               dir_rows [DIR_N];

  freefall_interval_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Run time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("freefall_interval_detector_tb: errors");
      $finish;
    end
  end

  // Receiver stalls at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void clear_batch();
    batch_open = 1'b0;
    run_open   = 1'b0;
    run_t0     = '0;
    run_len    = '0;
    run_low    = '0;
    best_len   = '0;
    best_low   = fid_pkg::ACCEL_DEFAULT_MIN;
  endfunction

  // Folds one sample into the run state; returns 1 with the batch report on
  // the last sample of a batch.
  function automatic bit track_freefall(input fid_pkg::in_item_t s,
                                        output fid_pkg::out_item_t rep);
    logic signed [fid_pkg::ACCEL_W-1:0] a;
    a   = s.accel_sample;
    rep = '0;
    if (!batch_open) begin
      run_low    = a;
      batch_open = 1'b1;
    end
    if (a < thr_q) begin
      if (!run_open) begin
        run_t0   = s.sample_time;
        run_open = 1'b1;
      end else begin
        run_len = s.sample_time - run_t0;
        if (a < run_low) run_low = a;
      end
      if (run_len > min_len_q && run_len > best_len) begin
        best_len = run_len;
        best_low = run_low;
      end
    end else begin
      run_low  = fid_pkg::ACCEL_TEN;
      run_len  = '0;
      run_open = 1'b0;
    end
    if (!s.last_sample) return 1'b0;
    rep.longest_duration = best_len;
    rep.run_min_accel    = best_low;
    clear_batch();
    return 1'b1;
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  function automatic row_t mk_row(input int accel, input int unsigned t, input bit last,
                                  input bit pin = 1'b0, input int unsigned dur = 0,
                                  input int mn = 0);
    row_t r;
    r.s.accel_sample          = accel;
    r.s.sample_time           = t;
    r.s.last_sample           = last;
    r.pinned                  = pin;
    r.want.longest_duration   = dur;
    r.want.run_min_accel      = mn;
    return r;
  endfunction

  // Observes handshakes at the rising edge: predicts on each accepted sample
  // request and checks each accepted result request.
  always @(posedge clk) begin : observe
    fid_pkg::out_item_t rep;
    fid_pkg::out_item_t want;
    in_taken  = rst_n && in_valid && !in_stall;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    if (cfg_taken) begin
      case (cfg_index)
        fid_pkg::REG_ACCEL_THRESHOLD: thr_q = cfg_data;
        fid_pkg::REG_MIN_DURATION:    min_len_q = cfg_data;
        default: ;
      endcase
    end
    if (in_taken && track_freefall(in_data, rep)) begin
      due_reports.push_back(pinned_on ? pinned_rep : rep);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        log_fault($sformatf("unexpected result: duration %0d min %0d",
                            out_data.longest_duration, out_data.run_min_accel));
      end else begin
        want = due_reports.pop_front();
        if (out_data.longest_duration !== want.longest_duration ||
            out_data.run_min_accel !== want.run_min_accel) begin
          log_fault($sformatf("mismatch: duration exp %0d got %0d, min exp %0d got %0d",
                              want.longest_duration, out_data.longest_duration,
                              want.run_min_accel, out_data.run_min_accel));
        end
      end
    end
  end

  // Offers one sample request after a random gap and holds it until taken.
  task automatic push_sample(input fid_pkg::in_item_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic write_reg(input logic [fid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every expected result is out and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_reports.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    fid_pkg::in_item_t                  s;
    logic signed [fid_pkg::ACCEL_W-1:0] phase_thr [PHASES];
    logic [fid_pkg::TIME_W-1:0]         phase_min [PHASES];
    logic [fid_pkg::TIME_W-1:0]         t;
    int                                 n;
    int                                 len;
    int                                 pick;

    thr_q     = '0;
    min_len_q = '0;
    clear_batch();

    // Directed rows under the reset configuration: threshold 0, no minimum.
    dir_rows = '{
      // Sample exactly at the threshold: no run, default report.
      mk_row(0, 0, 1'b1, 1'b1, 0, fid_pkg::ACCEL_DEFAULT_MIN),
      // A lone freefall sample opens a run of zero length.
      mk_row(-1, 5, 1'b1, 1'b1, 0, fid_pkg::ACCEL_DEFAULT_MIN),
      // A run that keeps growing and picks up a new minimum.
      mk_row(-100, 10, 1'b0),
      mk_row(-200, 15, 1'b0),
      mk_row(-50, 30, 1'b1),
      // Extremes: the run reopens after a full-scale sample and the
      // timestamp goes backwards, so the duration wraps to all ones.
      mk_row(32'h8000_0000, 32'hFFFF_FFFF, 1'b0),
      mk_row(32'h7FFF_FFFF, 0, 1'b0),
      mk_row(-1, 100, 1'b0),
      mk_row(32'h8000_0000, 99, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000),
      // A later, shorter run does not replace the best one.
      mk_row(-5, 0, 1'b0),
      mk_row(-6, 50, 1'b0),
      mk_row(3, 60, 1'b0),
      mk_row(-9, 70, 1'b0),
      mk_row(-10, 90, 1'b1),
      // A later run of equal length does not replace the best one either.
      mk_row(-1, 0, 1'b0),
      mk_row(-2, 10, 1'b0),
      mk_row(1, 11, 1'b0),
      mk_row(-3, 20, 1'b0),
      mk_row(-4, 30, 1'b1),
      // First sample above the threshold, then a run that never lasts.
      mk_row(5, 7, 1'b0),
      mk_row(-7, 8, 1'b1, 1'b1, 0, fid_pkg::ACCEL_DEFAULT_MIN),
      // The running minimum starts as the first sample of the batch.
      mk_row(-300, 1, 1'b0),
      mk_row(-2, 4, 1'b1)
    };

    phase_thr = '{32'sd700000, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000, $urandom,
                  int'($urandom_range(4000)) - 2000, 32'sd0,
                  fid_pkg::ACCEL_DEFAULT_MIN};
    phase_min = '{32'd0, 32'd20, 32'd0, 32'd0, 32'hFFFF_FFFF,
                  $urandom_range(100), 32'd0, 32'd5};

    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      pinned_on  = dir_rows[i].pinned;
      pinned_rep = dir_rows[i].want;
      push_sample(dir_rows[i].s);
    end
    pinned_on = 1'b0;
    settle();

    // Random batches, one configuration and idle pattern per phase.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(fid_pkg::REG_ACCEL_THRESHOLD, phase_thr[p]);
      write_reg(fid_pkg::REG_MIN_DURATION, phase_min[p]);
      send_gap_pct = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 11 : 0;
      stall_pct    = (p % 4 == 2) ? 72 : (p % 4 == 3) ? 11 : 0;
      n = 0;
      t = $urandom;
      while (n < PHASE_ITEMS) begin
        len = $urandom_range(12, 1);
        if ($urandom_range(3) == 0) t = $urandom;
        for (int k = 0; k < len; k++) begin
          // Mostly just under the threshold, some at its edge, some noise.
          pick = $urandom_range(99);
          if (pick < 70)
            s.accel_sample = phase_thr[p] + (int'($urandom_range(3000)) - 2500);
          else if (pick < 85)
            s.accel_sample = phase_thr[p] + int'($urandom_range(2)) - 1;
          else if (pick < 95)
            s.accel_sample = $urandom;
          else
            s.accel_sample = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
          if ($urandom_range(19) == 0) t = $urandom;
          else t = t + $urandom_range(40, 1);
          s.sample_time = t;
          s.last_sample = (k == len - 1);
          push_sample(s);
          n++;
        end
      end
      settle();
    end

    while (due_reports.size() != 0) begin
      void'(due_reports.pop_front());
      log_fault("expected result never arrived");
    end

    if (fault_count == 0) begin
      $display("freefall_interval_detector_tb: clean");
    end else begin
      $display("freefall_interval_detector_tb: errors");
    end
    $finish;
  end

endmodule
